[rtl/core/tes_pkg.sv]
package tes_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int POS_W       = 7;

    localparam logic [POS_W-1:0] DEPTH_POS = POS_W'(TABLE_DEPTH);

    localparam logic [2:0] KIND_TICK      = 3'd0;
    localparam logic [2:0] KIND_START     = 3'd1;
    localparam logic [2:0] KIND_LOAD_NOTE = 3'd2;
    localparam logic [2:0] KIND_LOAD_ENV0 = 3'd3;
    localparam logic [2:0] KIND_LOAD_ENV1 = 3'd4;

    localparam logic [2:0] TGT_ENABLE  = 3'd0;
    localparam logic [2:0] TGT_VOLUME  = 3'd1;
    localparam logic [2:0] TGT_FREQ_LO = 3'd2;
    localparam logic [2:0] TGT_FREQ_HI = 3'd3;
    localparam logic [2:0] TGT_ENV0    = 3'd4;
    localparam logic [2:0] TGT_ENV1    = 3'd5;

    localparam logic [2:0] CFG_NOTE_COUNT  = 3'd0;
    localparam logic [2:0] CFG_ENV0_COUNT  = 3'd1;
    localparam logic [2:0] CFG_ENV1_COUNT  = 3'd2;
    localparam logic [2:0] CFG_LOOPING     = 3'd3;
    localparam logic [2:0] CFG_PAUSE_CODE  = 3'd4;
    localparam logic [2:0] CFG_SILENT_CODE = 3'd5;

    localparam logic [7:0] ENABLE_ON  = 8'h80;
    localparam logic [7:0] ENABLE_OFF = 8'h00;

    typedef struct packed {
        logic [2:0]  kind;
        logic [5:0]  entry_index;
        logic [10:0] entry_value;
        logic [7:0]  entry_ticks;
        logic [3:0]  level;
    } item_t;

    typedef struct packed {
        logic [2:0] target_reg;
        logic [7:0] write_value;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [10:0] note_freq;
        logic [7:0]  note_ticks;
        logic [7:0]  env0_value;
        logic [7:0]  env0_ticks;
        logic [7:0]  env1_value;
        logic [7:0]  env1_ticks;
    } entry_t;

endpackage

[rtl/core/tone_envelope_sequencer.sv]
// Load transactions are taken one per cycle while item_stall is low, and produce no results.
// A start or tick transaction holds the sequencer; it makes at most one table read per cycle
// from the single-port table memory and at most one register write per cycle.
// Each register write passes through a pending register and the result queue before
// it appears on the result port. The result queue has 16 entries and admits the next
// transaction while at most 7 results wait. Reset clears the playing flag, positions,
// tick counters, queue, looping flag and codes, and sets the entry counts to 1.
module tone_envelope_sequencer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  logic             item_valid,
    output logic             item_stall,
    input  tes_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output tes_pkg::result_t result
);
    import tes_pkg::*;

    localparam int Q_DEPTH     = 16;
    localparam int Q_AW        = $clog2(Q_DEPTH);
    localparam int MAX_RESULTS = 8;
    localparam int Q_ROOM      = Q_DEPTH - MAX_RESULTS - 1;

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_S0     = 5'd1;
    localparam logic [4:0] ST_S1     = 5'd2;
    localparam logic [4:0] ST_S2     = 5'd3;
    localparam logic [4:0] ST_S3     = 5'd4;
    localparam logic [4:0] ST_S4     = 5'd5;
    localparam logic [4:0] ST_S5     = 5'd6;
    localparam logic [4:0] ST_N_RD   = 5'd7;
    localparam logic [4:0] ST_N_EV   = 5'd8;
    localparam logic [4:0] ST_N_STOP = 5'd9;
    localparam logic [4:0] ST_N_FR   = 5'd10;
    localparam logic [4:0] ST_N_LO   = 5'd11;
    localparam logic [4:0] ST_N_HI   = 5'd12;
    localparam logic [4:0] ST_E_RD   = 5'd13;
    localparam logic [4:0] ST_E_EV   = 5'd14;
    localparam logic [4:0] ST_E_WR   = 5'd15;
    localparam logic [4:0] ST_FIN    = 5'd16;

    logic [6:0]  note_count_reg;
    logic [6:0]  env0_count_reg;
    logic [6:0]  env1_count_reg;
    logic        looping_reg;
    logic [10:0] pause_code_reg;
    logic [10:0] silent_code_reg;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    entry_t             tbl_mem [TABLE_DEPTH];
    entry_t             rd_data_reg;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic               mem_wr_note;
    logic               mem_wr_env0;
    logic               mem_wr_env1;

    logic [4:0]       state_reg, state_next;
    logic             playing_reg, playing_next;
    logic [POS_W-1:0] note_pos_reg, note_pos_next;
    logic [POS_W-1:0] env0_pos_reg, env0_pos_next;
    logic [POS_W-1:0] env1_pos_reg, env1_pos_next;
    logic [7:0]       note_cnt_reg, note_cnt_next;
    logic [7:0]       env0_cnt_reg, env0_cnt_next;
    logic [7:0]       env1_cnt_reg, env1_cnt_next;
    logic             trk_reg, trk_next;
    logic             is_start_reg, is_start_next;
    logic [3:0]       level_reg, level_next;

    logic             accept;
    logic             fsm_free;
    logic             room;
    logic [POS_W-1:0] nc;
    logic [POS_W-1:0] c0;
    logic [POS_W-1:0] c1;
    logic [POS_W-1:0] e_c;
    logic [POS_W-1:0] e_pos;
    logic [7:0]       e_cnt;
    logic [7:0]       e_ticks;
    logic [7:0]       e_val;
    logic [7:0]       n_cnt1;
    logic [POS_W-1:0] n_pos1;
    logic [7:0]       e_cnt1;
    logic [POS_W-1:0] e_pos1;
    logic             e_upd;
    logic [POS_W-1:0] e_pos_wr;
    logic [7:0]       e_cnt_wr;

    logic       emit_v;
    logic [2:0] emit_tgt;
    logic [7:0] emit_val;
    logic       pend_valid_reg;
    logic [2:0] pend_tgt_reg;
    logic [7:0] pend_val_reg;
    logic       push;
    result_t    push_data;
    logic       pop;

    result_t         q_mem [Q_DEPTH];
    logic [Q_AW-1:0] q_head_reg;
    logic [Q_AW-1:0] q_tail_reg;
    logic [Q_AW:0]   q_count_reg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            note_count_reg  <= 7'd1;
            env0_count_reg  <= 7'd1;
            env1_count_reg  <= 7'd1;
            looping_reg     <= 1'b0;
            pause_code_reg  <= '0;
            silent_code_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                CFG_NOTE_COUNT:  note_count_reg  <= pwdata[6:0];
                CFG_ENV0_COUNT:  env0_count_reg  <= pwdata[6:0];
                CFG_ENV1_COUNT:  env1_count_reg  <= pwdata[6:0];
                CFG_LOOPING:     looping_reg     <= pwdata[0];
                CFG_PAUSE_CODE:  pause_code_reg  <= pwdata[10:0];
                CFG_SILENT_CODE: silent_code_reg <= pwdata[10:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            CFG_NOTE_COUNT:  prdata = 32'(note_count_reg);
            CFG_ENV0_COUNT:  prdata = 32'(env0_count_reg);
            CFG_ENV1_COUNT:  prdata = 32'(env1_count_reg);
            CFG_LOOPING:     prdata = 32'(looping_reg);
            CFG_PAUSE_CODE:  prdata = 32'(pause_code_reg);
            CFG_SILENT_CODE: prdata = 32'(silent_code_reg);
            default:         prdata = '0;
        endcase
    end

    assign fsm_free   = (state_reg == ST_IDLE) || (state_reg == ST_FIN);
    assign room       = q_count_reg <= (Q_AW + 1)'(Q_ROOM);
    assign item_stall = ~(fsm_free & room);
    assign accept     = item_valid & ~item_stall;

    assign wr_addr     = item.entry_index;
    assign mem_wr_note = accept && (item.kind == KIND_LOAD_NOTE);
    assign mem_wr_env0 = accept && (item.kind == KIND_LOAD_ENV0);
    assign mem_wr_env1 = accept && (item.kind == KIND_LOAD_ENV1);

    always_ff @(posedge clk)
    begin
        if (mem_wr_note)
        begin
            tbl_mem[wr_addr].note_freq  <= item.entry_value;
            tbl_mem[wr_addr].note_ticks <= item.entry_ticks;
        end
        if (mem_wr_env0)
        begin
            tbl_mem[wr_addr].env0_value <= item.entry_value[7:0];
            tbl_mem[wr_addr].env0_ticks <= item.entry_ticks;
        end
        if (mem_wr_env1)
        begin
            tbl_mem[wr_addr].env1_value <= item.entry_value[7:0];
            tbl_mem[wr_addr].env1_ticks <= item.entry_ticks;
        end
        if (rd_en)
        begin
            rd_data_reg <= tbl_mem[rd_addr];
        end
    end

    assign nc = (note_count_reg > DEPTH_POS) ? DEPTH_POS : note_count_reg;
    assign c0 = (env0_count_reg > DEPTH_POS) ? DEPTH_POS : env0_count_reg;
    assign c1 = (env1_count_reg > DEPTH_POS) ? DEPTH_POS : env1_count_reg;

    assign e_c     = trk_reg ? c1 : c0;
    assign e_pos   = trk_reg ? env1_pos_reg : env0_pos_reg;
    assign e_cnt   = trk_reg ? env1_cnt_reg : env0_cnt_reg;
    assign e_ticks = trk_reg ? rd_data_reg.env1_ticks : rd_data_reg.env0_ticks;
    assign e_val   = trk_reg ? rd_data_reg.env1_value : rd_data_reg.env0_value;

    assign n_cnt1 = note_cnt_reg + 8'd1;
    assign n_pos1 = note_pos_reg + POS_W'(1);
    assign e_cnt1 = e_cnt + 8'd1;
    assign e_pos1 = e_pos + POS_W'(1);

    always_comb
    begin
        state_next    = state_reg;
        playing_next  = playing_reg;
        note_pos_next = note_pos_reg;
        env0_pos_next = env0_pos_reg;
        env1_pos_next = env1_pos_reg;
        note_cnt_next = note_cnt_reg;
        env0_cnt_next = env0_cnt_reg;
        env1_cnt_next = env1_cnt_reg;
        trk_next      = trk_reg;
        is_start_next = is_start_reg;
        level_next    = level_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        emit_v        = 1'b0;
        emit_tgt      = TGT_ENABLE;
        emit_val      = ENABLE_OFF;
        e_upd         = 1'b0;
        e_pos_wr      = e_pos;
        e_cnt_wr      = e_cnt;

        case (state_reg)
            ST_IDLE, ST_FIN:
            begin
                state_next = ST_IDLE;
                if (accept && (item.kind == KIND_START))
                begin
                    state_next    = ST_S0;
                    is_start_next = 1'b1;
                    level_next    = item.level;
                end
                else if (accept && (item.kind == KIND_TICK) && playing_reg)
                begin
                    state_next    = ST_N_RD;
                    is_start_next = 1'b0;
                    level_next    = item.level;
                end
            end
            ST_S0:
            begin
                playing_next  = 1'b1;
                note_pos_next = '0;
                env0_pos_next = '0;
                env1_pos_next = '0;
                note_cnt_next = '0;
                env0_cnt_next = '0;
                env1_cnt_next = '0;
                rd_en         = 1'b1;
                rd_addr       = '0;
                emit_v        = 1'b1;
                emit_tgt      = TGT_ENABLE;
                emit_val      = ENABLE_ON;
                state_next    = ST_S1;
            end
            ST_S1:
            begin
                emit_v     = 1'b1;
                emit_tgt   = TGT_VOLUME;
                emit_val   = {level_reg, level_reg};
                state_next = ST_S2;
            end
            ST_S2:
            begin
                emit_v     = 1'b1;
                emit_tgt   = TGT_FREQ_LO;
                emit_val   = rd_data_reg.note_freq[7:0];
                state_next = ST_S3;
            end
            ST_S3:
            begin
                emit_v     = 1'b1;
                emit_tgt   = TGT_FREQ_HI;
                emit_val   = {5'd0, rd_data_reg.note_freq[10:8]};
                state_next = ST_S4;
            end
            ST_S4:
            begin
                emit_v     = 1'b1;
                emit_tgt   = TGT_ENV0;
                emit_val   = rd_data_reg.env0_value;
                state_next = ST_S5;
            end
            ST_S5:
            begin
                emit_v     = 1'b1;
                emit_tgt   = TGT_ENV1;
                emit_val   = rd_data_reg.env1_value;
                state_next = is_start_reg ? ST_FIN : ST_E_RD;
            end
            ST_N_RD:
            begin
                trk_next = 1'b0;
                if (note_pos_reg < nc)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = note_pos_reg[ADDR_W-1:0];
                    state_next = ST_N_EV;
                end
                else
                begin
                    state_next = ST_E_RD;
                end
            end
            ST_N_EV:
            begin
                if (n_cnt1 >= rd_data_reg.note_ticks)
                begin
                    note_cnt_next = '0;
                    note_pos_next = n_pos1;
                    if (n_pos1 >= nc)
                    begin
                        if (!looping_reg)
                        begin
                            emit_v     = 1'b1;
                            emit_tgt   = TGT_ENABLE;
                            emit_val   = ENABLE_OFF;
                            state_next = ST_N_STOP;
                        end
                        else
                        begin
                            state_next = ST_S0;
                        end
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = n_pos1[ADDR_W-1:0];
                        state_next = ST_N_FR;
                    end
                end
                else
                begin
                    note_cnt_next = n_cnt1;
                    state_next    = ST_E_RD;
                end
            end
            ST_N_STOP:
            begin
                emit_v       = 1'b1;
                emit_tgt     = TGT_VOLUME;
                emit_val     = 8'h00;
                playing_next = 1'b0;
                state_next   = ST_E_RD;
            end
            ST_N_FR:
            begin
                emit_v   = 1'b1;
                emit_tgt = TGT_ENABLE;
                if ((rd_data_reg.note_freq == pause_code_reg) ||
                    (rd_data_reg.note_freq == silent_code_reg))
                begin
                    emit_val   = ENABLE_OFF;
                    state_next = ST_E_RD;
                end
                else
                begin
                    emit_val   = ENABLE_ON;
                    state_next = ST_N_LO;
                end
            end
            ST_N_LO:
            begin
                emit_v     = 1'b1;
                emit_tgt   = TGT_FREQ_LO;
                emit_val   = rd_data_reg.note_freq[7:0];
                state_next = ST_N_HI;
            end
            ST_N_HI:
            begin
                emit_v     = 1'b1;
                emit_tgt   = TGT_FREQ_HI;
                emit_val   = {5'd0, rd_data_reg.note_freq[10:8]};
                state_next = ST_E_RD;
            end
            ST_E_RD:
            begin
                if (e_pos < e_c)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = e_pos[ADDR_W-1:0];
                    state_next = ST_E_EV;
                end
                else if (trk_reg)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    trk_next   = 1'b1;
                    state_next = ST_E_RD;
                end
            end
            ST_E_EV:
            begin
                e_upd = 1'b1;
                if (e_cnt1 >= e_ticks)
                begin
                    e_cnt_wr = '0;
                    if (looping_reg && (e_pos1 >= e_c))
                    begin
                        e_pos_wr   = '0;
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = ST_E_WR;
                    end
                    else if (e_pos1 < e_c)
                    begin
                        e_pos_wr   = e_pos1;
                        rd_en      = 1'b1;
                        rd_addr    = e_pos1[ADDR_W-1:0];
                        state_next = ST_E_WR;
                    end
                    else
                    begin
                        e_pos_wr   = e_pos1;
                        trk_next   = 1'b1;
                        state_next = trk_reg ? ST_FIN : ST_E_RD;
                    end
                end
                else
                begin
                    e_cnt_wr   = e_cnt1;
                    trk_next   = 1'b1;
                    state_next = trk_reg ? ST_FIN : ST_E_RD;
                end
            end
            ST_E_WR:
            begin
                emit_v     = 1'b1;
                emit_tgt   = trk_reg ? TGT_ENV1 : TGT_ENV0;
                emit_val   = e_val;
                trk_next   = 1'b1;
                state_next = trk_reg ? ST_FIN : ST_E_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (e_upd)
        begin
            if (trk_reg)
            begin
                env1_pos_next = e_pos_wr;
                env1_cnt_next = e_cnt_wr;
            end
            else
            begin
                env0_pos_next = e_pos_wr;
                env0_cnt_next = e_cnt_wr;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            playing_reg  <= 1'b0;
            note_pos_reg <= '0;
            env0_pos_reg <= '0;
            env1_pos_reg <= '0;
            note_cnt_reg <= '0;
            env0_cnt_reg <= '0;
            env1_cnt_reg <= '0;
            trk_reg      <= 1'b0;
            is_start_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            playing_reg  <= playing_next;
            note_pos_reg <= note_pos_next;
            env0_pos_reg <= env0_pos_next;
            env1_pos_reg <= env1_pos_next;
            note_cnt_reg <= note_cnt_next;
            env0_cnt_reg <= env0_cnt_next;
            env1_cnt_reg <= env1_cnt_next;
            trk_reg      <= trk_next;
            is_start_reg <= is_start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg <= level_next;
    end

    // The newest register write is held in a pending register until the next write, so that the final one of a
    // transaction can be marked when the sequencer reaches its finishing state.
    always_comb
    begin
        push_data.target_reg  = pend_tgt_reg;
        push_data.write_value = pend_val_reg;
        push_data.last        = (state_reg == ST_FIN);
        push                  = pend_valid_reg && (emit_v || (state_reg == ST_FIN));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (emit_v)
        begin
            pend_valid_reg <= 1'b1;
        end
        else if (state_reg == ST_FIN)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_v)
        begin
            pend_tgt_reg <= emit_tgt;
            pend_val_reg <= emit_val;
        end
        if (push)
        begin
            q_mem[q_tail_reg] <= push_data;
        end
    end

    assign result_valid = (q_count_reg != '0);
    assign result       = q_mem[q_head_reg];
    assign pop          = result_valid & ~result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_head_reg  <= '0;
            q_tail_reg  <= '0;
            q_count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                q_tail_reg <= q_tail_reg + Q_AW'(1);
            end
            if (pop)
            begin
                q_head_reg <= q_head_reg + Q_AW'(1);
            end
            q_count_reg <= q_count_reg + (Q_AW + 1)'(push) - (Q_AW + 1)'(pop);
        end
    end

endmodule

[rtl/core/tes_checker.sv]
module tes_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input logic             result_valid,
    input logic             result_stall,
    input tes_pkg::result_t result,
    input logic             pready
);
    import tes_pkg::*;

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("Stalled result transaction changed or was dropped.");

    a_empty_after_reset: assert property (@(posedge clk)
        !rst_n |=> !result_valid && pready)
        else $error("Result transaction offered straight after reset.");

    a_target_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.target_reg <= TGT_ENV1)
        else $error("Result transaction names no channel register.");

    a_enable_value: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.target_reg == TGT_ENABLE) |->
            (result.write_value == ENABLE_ON) || (result.write_value == ENABLE_OFF))
        else $error("Enable write carries an unexpected value.");

    a_stall_idle_input: assert property (@(posedge clk) disable iff (!rst_n)
        !item_valid && $past(!rst_n) |-> !item_stall)
        else $error("Input stalled straight after reset.");

endmodule

bind tone_envelope_sequencer tes_checker u_tes_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .pready       (pready)
);
